// ===== src/ira_pkg.sv =====
// Shared types and codes of the interval range table.
package ira_pkg;

  // Request operation codes
  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Source of a boundary emitted into the rebuilt table
  localparam logic [1:0] SRC_STORED = 2'd0;
  localparam logic [1:0] SRC_BEGIN  = 2'd1;
  localparam logic [1:0] SRC_END    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;       // capture request fields, clear scan index
    logic       idx_clear;  // restart the scan at entry zero
    logic       idx_inc;    // advance the scan index
    logic       acc_load;   // take the stored value into the accumulator
    logic       scan_init;  // clear rebuild count, seed previous value
    logic       emit;       // offer one boundary to the rebuilt table
    logic [1:0] emit_sel;   // which boundary is offered
    logic       respond;    // commit the table and present the result
  } ira_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_end;      // scan index has passed the stored entries
    logic key_le_tgt;  // stored key at or below the lookup target
    logic key_lt_b;    // stored key below range begin
    logic key_gt_e;    // stored key above range end
    logic op_lookup;   // request is a lookup
    logic empty;       // assign range is empty
  } ira_status_t;

endpackage

// ===== src/interval_range_table.sv =====
// Top level of the interval range table.
//
// Sorted table of signed boundary keys, each with a value; keys below the
// first boundary map to default_value. A request is taken when start is high
// and busy is low. op = 0 writes new_value over [range_begin, range_end);
// op = 1 returns the value in force at query_key. Every request yields one
// result, shown for exactly one cycle with result_valid high; the receiver
// cannot stall and must take it then.
// Lookup: scans stored entries from the first, one entry a cycle, through
// one RAM read port. Assign: a lookup of range_end, then a rebuild pass
// that streams the canonical table into the idle half of a ping-pong RAM
// pair, one entry a cycle. An empty range skips the rebuild. busy stays
// high for the whole request; a new request can be taken in the cycle
// the result is shown. default_value is written through cfg_valid/cfg_data
// (cfg_ready is always high); the user must write it only while the block
// is idle, which the block itself does not enforce. Reset clears the table
// to empty and the default to zero; the RAMs need no clearing.
module interval_range_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic signed [KEY_BITS-1:0]           range_begin,
  input  logic signed [KEY_BITS-1:0]           range_end,
  input  logic [VALUE_BITS-1:0]                new_value,
  input  logic signed [KEY_BITS-1:0]           query_key,
  output logic                                 result_valid,
  output logic [VALUE_BITS-1:0]                read_value,
  output logic                                 overflow,
  output logic [$clog2(TABLE_DEPTH + 1)-1:0]   entry_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [VALUE_BITS-1:0]                cfg_data
);

  ira_pkg::ira_cmd_t    cmd;
  ira_pkg::ira_status_t status;

  assign cfg_ready = 1'b1;

  ira_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ira_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .op           (op),
    .range_begin  (range_begin),
    .range_end    (range_end),
    .new_value    (new_value),
    .query_key    (query_key),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .read_value   (read_value),
    .overflow     (overflow),
    .entry_count  (entry_count),
    .result_valid (result_valid)
  );

endmodule

// ===== src/ira_ram.sv =====
// Generic single write port RAM with registered read.
module ira_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ira_ctrl.sv =====
// Controller state machine of the interval range table.
module ira_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ira_pkg::ira_status_t status,
  output ira_pkg::ira_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_LOOK    = 3'd1;
  localparam logic [2:0] S_SCAN_LO = 3'd2;
  localparam logic [2:0] S_EMIT_B  = 3'd3;
  localparam logic [2:0] S_EMIT_E  = 3'd4;
  localparam logic [2:0] S_SCAN_HI = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // Sequence the scan, rebuild and response steps
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!status.op_lookup && status.empty) begin
          state_next = S_FINISH;
        end else if (status.at_end || !status.key_le_tgt) begin
          if (status.op_lookup) begin
            state_next = S_FINISH;
          end else begin
            cmd.idx_clear = 1'b1;
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_LO;
          end
        end else begin
          cmd.acc_load = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_SCAN_LO: begin
        if (!status.at_end && status.key_lt_b) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = ira_pkg::SRC_STORED;
          cmd.idx_inc  = 1'b1;
        end else begin
          state_next = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = ira_pkg::SRC_BEGIN;
        state_next   = S_EMIT_E;
      end
      S_EMIT_E: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = ira_pkg::SRC_END;
        state_next   = S_SCAN_HI;
      end
      S_SCAN_HI: begin
        if (status.at_end) begin
          state_next = S_FINISH;
        end else begin
          cmd.emit     = status.key_gt_e;
          cmd.emit_sel = ira_pkg::SRC_STORED;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_FINISH: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/ira_dpath.sv =====
// Datapath of the interval range table: ping-pong tables, scan and rebuild.
module ira_dpath #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 16,
  parameter int VALUE_BITS  = 8,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int MW = $clog2(TABLE_DEPTH + 3),
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ira_pkg::ira_cmd_t          cmd,
  output ira_pkg::ira_status_t       status,
  input  logic                       op,
  input  logic signed [KEY_BITS-1:0] range_begin,
  input  logic signed [KEY_BITS-1:0] range_end,
  input  logic [VALUE_BITS-1:0]      new_value,
  input  logic signed [KEY_BITS-1:0] query_key,
  input  logic                       cfg_we,
  input  logic [VALUE_BITS-1:0]      cfg_data,
  output logic [VALUE_BITS-1:0]      read_value,
  output logic                       overflow,
  output logic [CW-1:0]              entry_count,
  output logic                       result_valid
);

  localparam int EW = KEY_BITS + VALUE_BITS;

  logic                       bank;
  logic [CW-1:0]              used;
  logic [CW-1:0]              used_next;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              idx_next;
  logic [MW-1:0]              m;
  logic [VALUE_BITS-1:0]      prev;
  logic [VALUE_BITS-1:0]      acc;
  logic [VALUE_BITS-1:0]      dflt;
  logic                       op_r;
  logic signed [KEY_BITS-1:0] b_r;
  logic signed [KEY_BITS-1:0] e_r;
  logic signed [KEY_BITS-1:0] q_r;
  logic [VALUE_BITS-1:0]      v_r;
  logic signed [KEY_BITS-1:0] tgt;
  logic [EW-1:0]              rdata0;
  logic [EW-1:0]              rdata1;
  logic signed [KEY_BITS-1:0] rkey;
  logic [VALUE_BITS-1:0]      rval;
  logic signed [KEY_BITS-1:0] ekey;
  logic [VALUE_BITS-1:0]      eval_v;
  logic                       do_write;
  logic                       wr_en;
  logic                       empty;
  logic                       commit;
  logic                       over;

  // Stored entry at the scan index from the live bank
  assign {rkey, rval} = bank ? rdata1 : rdata0;
  assign tgt   = (op_r == ira_pkg::OP_LOOKUP) ? q_r : e_r;
  assign empty = !(b_r < e_r);
  assign over  = (m > MW'(TABLE_DEPTH));

  assign status.at_end     = (idx >= used);
  assign status.key_le_tgt = (rkey <= tgt);
  assign status.key_lt_b   = (rkey < b_r);
  assign status.key_gt_e   = (rkey > e_r);
  assign status.op_lookup  = (op_r == ira_pkg::OP_LOOKUP);
  assign status.empty      = empty;

  // Next scan index drives the read address, so the registered read data matches the index
  always_comb begin
    if (cmd.load || cmd.idx_clear) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + CW'(1);
    end else begin
      idx_next = idx;
    end
  end

  // Select the boundary offered to the rebuilt table
  always_comb begin
    case (cmd.emit_sel)
      ira_pkg::SRC_BEGIN: begin
        ekey   = b_r;
        eval_v = v_r;
      end
      ira_pkg::SRC_END: begin
        ekey   = e_r;
        eval_v = acc;
      end
      default: begin
        ekey   = rkey;
        eval_v = rval;
      end
    endcase
  end

  // Drop boundaries that repeat the previous value
  assign do_write = cmd.emit && (eval_v != prev);
  assign wr_en    = do_write && (m < MW'(TABLE_DEPTH));
  assign commit   = cmd.respond && (op_r == ira_pkg::OP_ASSIGN) && !empty && !over;
  assign used_next = commit ? m[CW-1:0] : used;

  ira_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (wr_en && bank),
    .waddr (m[AW-1:0]),
    .wdata ({ekey, eval_v}),
    .raddr (idx_next[AW-1:0]),
    .rdata (rdata0)
  );

  ira_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (wr_en && !bank),
    .waddr (m[AW-1:0]),
    .wdata ({ekey, eval_v}),
    .raddr (idx_next[AW-1:0]),
    .rdata (rdata1)
  );

  // Capture request fields, track the scan and register the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      b_r  <= range_begin;
      e_r  <= range_end;
      q_r  <= query_key;
      v_r  <= new_value;
      acc  <= dflt;
    end else if (cmd.acc_load) begin
      acc <= rval;
    end
    if (cmd.scan_init) begin
      prev <= dflt;
    end else if (do_write) begin
      prev <= eval_v;
    end
    if (cmd.respond) begin
      read_value  <= (op_r == ira_pkg::OP_LOOKUP) ? acc : '0;
      overflow    <= (op_r == ira_pkg::OP_ASSIGN) && !empty && over;
      entry_count <= used_next;
    end
  end

  // Control state: bank, fill count, index, rebuild count, default register, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      bank         <= 1'b0;
      used         <= '0;
      idx          <= '0;
      m            <= '0;
      dflt         <= '0;
      result_valid <= 1'b0;
    end else begin
      idx          <= idx_next;
      used         <= used_next;
      result_valid <= cmd.respond;
      if (commit) begin
        bank <= !bank;
      end
      if (cmd.scan_init) begin
        m <= '0;
      end else if (do_write) begin
        m <= m + MW'(1);
      end
      if (cfg_we) begin
        dflt <= cfg_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe in consecutive cycles");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");
  a_rebuild_bound: assert property (@(posedge clk) disable iff (rst)
    m <= MW'(TABLE_DEPTH + 2))
    else $error("rebuild count beyond work depth");
  a_ovf_no_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.respond && over && (op_r == ira_pkg::OP_ASSIGN)) |=> $stable(used))
    else $error("refused assign changed the table");
`endif

endmodule

// ===== dv/interval_range_table_checker.sv =====
// Checker for the interval range table: predicts each result and compares it.
`timescale 1ns / 1ps

module interval_range_table_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               op,
  input  logic signed [15:0] range_begin,
  input  logic signed [15:0] range_end,
  input  logic [7:0]         new_value,
  input  logic signed [15:0] query_key,
  input  logic               result_valid,
  input  logic [7:0]         read_value,
  input  logic               overflow,
  input  logic [4:0]         entry_count,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int DEPTH = 16;
  localparam int WORK  = DEPTH + 2;

  typedef struct packed {
    logic [7:0] read_value;
    logic       overflow;
    logic [4:0] entry_count;
  } outcome_t;

  logic signed [15:0] bkey [DEPTH];
  logic [7:0]         bval [DEPTH];
  int                 nused;
  logic [7:0]         dflt;
  outcome_t           outcome_q[$];

  assign pending = outcome_q.size();

  // Value in force at a key: last boundary at or below it, else the default
  function automatic logic [7:0] value_at(logic signed [15:0] key);
    logic [7:0] v;
    v = dflt;
    for (int i = 0; i < nused; i++) begin
      if (bkey[i] <= key) v = bval[i];
      else break;
    end
    return v;
  endfunction

  // Rebuild the canonical table over [b, e); return 1 when it would not fit
  function automatic logic write_range(logic signed [15:0] b, logic signed [15:0] e,
                                       logic [7:0] v);
    logic signed [15:0] wk [WORK];
    logic [7:0]         wv [WORK];
    logic signed [15:0] ck [WORK];
    logic [7:0]         cv [WORK];
    int                 n;
    int                 m;
    logic [7:0]         prev;
    n = 0;
    m = 0;
    if (!(b < e)) return 1'b0;
    wv[1] = value_at(e);
    for (int i = 0; i < nused; i++) begin
      if (bkey[i] < b) begin
        wk[n] = bkey[i];
        wv[n] = bval[i];
        n++;
      end
    end
    ck[0] = e;
    cv[0] = value_at(e);
    wk[n] = b; wv[n] = v; n++;
    wk[n] = e; wv[n] = cv[0]; n++;
    for (int i = 0; i < nused; i++) begin
      if (bkey[i] > e && n < WORK) begin
        wk[n] = bkey[i];
        wv[n] = bval[i];
        n++;
      end
    end
    // Drop entries that repeat the value before them
    prev = dflt;
    for (int i = 0; i < n; i++) begin
      if (wv[i] != prev) begin
        ck[m] = wk[i];
        cv[m] = wv[i];
        m++;
        prev = wv[i];
      end
    end
    if (m > DEPTH) return 1'b1;
    for (int i = 0; i < m; i++) begin
      bkey[i] = ck[i];
      bval[i] = cv[i];
    end
    nused = m;
    return 1'b0;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      nused = 0;
      dflt = '0;
      outcome_q.delete();
    end else begin
      // Compare the result shown in this cycle
      if (result_valid) begin
        got = '{read_value, overflow, entry_count};
        if (outcome_q.size() == 0) begin
          $display("MISMATCH at %0t: result with no request waiting", $time);
          fail_count++;
        end else begin
          want = outcome_q.pop_front();
          if (got.read_value != want.read_value)
            report("read_value", got.read_value, want.read_value);
          if (got.overflow != want.overflow)
            report("overflow", got.overflow, want.overflow);
          if (got.entry_count != want.entry_count)
            report("entry_count", got.entry_count, want.entry_count);
        end
      end
      // Predict the accepted request
      if (start && !busy) begin
        want = '0;
        if (op == ira_pkg::OP_ASSIGN)
          want.overflow = write_range(range_begin, range_end, new_value);
        else want.read_value = value_at(query_key);
        want.entry_count = 5'(nused);
        outcome_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) dflt = cfg_data;
    end
  end

endmodule

// ===== dv/interval_range_table_tb.sv =====
// Testbench top for the interval range table: stimulus, clock, reset, verdict.
`timescale 1ns / 1ps

module interval_range_table_tb;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               op;
  logic signed [15:0] range_begin;
  logic signed [15:0] range_end;
  logic [7:0]         new_value;
  logic signed [15:0] query_key;
  logic               result_valid;
  logic [7:0]         read_value;
  logic               overflow;
  logic [4:0]         entry_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_data;
  int                 fail_count;
  int                 pending;
  int                 item_no;

  interval_range_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .range_begin(range_begin), .range_end(range_end), .new_value(new_value),
    .query_key(query_key), .result_valid(result_valid), .read_value(read_value),
    .overflow(overflow), .entry_count(entry_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  interval_range_table_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .range_begin(range_begin), .range_end(range_end), .new_value(new_value),
    .query_key(query_key), .result_valid(result_valid), .read_value(read_value),
    .overflow(overflow), .entry_count(entry_count), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .fail_count(fail_count),
    .pending(pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Drive one request and hold it until taken; idle sometimes afterward
  task automatic send(logic o, int b, int e, int v, int k);
    start       <= 1'b1;
    op          <= o;
    range_begin <= 16'(b);
    range_end   <= 16'(e);
    new_value   <= 8'(v);
    query_key   <= 16'(k);
    do @(posedge clk); while (busy);
    item_no++;
    if ((item_no < 300 || item_no > 550) && $urandom_range(99) < 37) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write the default
  task automatic set_default(int v);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 8'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Keys mostly from a narrow window so ranges overlap; sometimes anywhere
  function automatic int pick_key();
    if ($urandom_range(99) < 80) return $urandom_range(0, 80) - 40;
    return $urandom_range(65535) - 32768;
  endfunction

  function automatic int pick_value();
    if ($urandom_range(99) < 70) return $urandom_range(0, 3);
    return $urandom_range(255);
  endfunction

  task automatic random_items(int count);
    int b;
    int e;
    for (int i = 0; i < count; i++) begin
      b = pick_key();
      e = ($urandom_range(99) < 85) ? b + $urandom_range(1, 20) : pick_key();
      if (e > 32767) e = 32767;
      if ($urandom_range(99) < 55)
        send(ira_pkg::OP_ASSIGN, b, e, pick_value(), pick_key());
      else
        send(ira_pkg::OP_LOOKUP, pick_key(), pick_key(), pick_value(), pick_key());
    end
  endtask

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    op          = ira_pkg::OP_ASSIGN;
    range_begin = '0;
    range_end   = '0;
    new_value   = '0;
    query_key   = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    item_no     = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, extremes, empty ranges, overflow
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, -32768);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, 32767);
    send(ira_pkg::OP_ASSIGN, -32768, 32767, 255, 0);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, 32767);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, -32768);
    send(ira_pkg::OP_ASSIGN, 5, 5, 7, 0);
    send(ira_pkg::OP_ASSIGN, 100, -100, 7, 0);
    send(ira_pkg::OP_ASSIGN, -32768, 32767, 0, 0);
    for (int i = 0; i < 10; i++) send(ira_pkg::OP_ASSIGN, 4 * i, 4 * i + 2, i + 1, 0);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, 37);
    send(ira_pkg::OP_ASSIGN, 1, 39, 128, 0);
    send(ira_pkg::OP_ASSIGN, 10, 20, 0, 0);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, 15);

    // Changed default with a stale table, then canonicalized by an assign
    set_default(255);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, -1000);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, 2);
    send(ira_pkg::OP_ASSIGN, -5, 0, 255, 0);
    send(ira_pkg::OP_LOOKUP, 0, 0, 0, -3);

    random_items(350);
    set_default(0);
    random_items(350);
    set_default($urandom_range(1, 254));
    random_items(200);
    set_default(255);
    random_items(180);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ira_pkg.sv
src/ira_ram.sv
src/ira_ctrl.sv
src/ira_dpath.sv
src/interval_range_table.sv
dv/interval_range_table_checker.sv
dv/interval_range_table_tb.sv
